### design/qclt_pkg.sv
// ----------------------------------------------------------------------------
// qclt_pkg: shared types and constants of the command-line tokenizer
// Character codes, quote mode encoding, result and queue entry types.
// ----------------------------------------------------------------------------
package qclt_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef enum logic [2:0] {
    QM_NONE   = 3'b001,
    QM_SINGLE = 3'b010,
    QM_DOUBLE = 3'b100
  } qmode_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       line_end;
    logic       quote_error;
    logic       run_last;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### design/qclt_if.sv
// ----------------------------------------------------------------------------
// qclt_if: valid/ready channels of the command-line tokenizer
// Input byte channel and token result channel.
// ----------------------------------------------------------------------------
interface qclt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_last;

  modport source (output valid, output in_byte, output line_last, input ready);
  modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

interface qclt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_end;
  logic       line_end;
  logic       quote_error;
  logic       run_last;

  modport source (output valid, output out_char, output char_valid, output token_end,
                  output line_end, output quote_error, output run_last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input token_end,
                  input line_end, input quote_error, input run_last, output ready);
endinterface

### design/qclt_front.sv
// ----------------------------------------------------------------------------
// qclt_front: byte classifier of the tokenizer
// Tracks quote mode, open token and pending escape, and builds the one or two
// results of each byte as one queue entry.
// ----------------------------------------------------------------------------
module qclt_front
  import qclt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  qclt_in_if.sink       in_ch,
  input  q_stat_t       q_stat,
  output logic          push,
  output entry_t        push_entry
);

  qmode_t mode_r, mode_nxt;
  logic   open_r, open_nxt;
  logic   pend_r, pend_nxt;

  logic       accept;
  logic [7:0] c;
  logic       last;
  logic       handled;
  logic       esc_v;
  logic [7:0] esc_ch;
  logic       main_v;
  logic       closed;
  logic       err;
  logic       tend;
  logic       is_sep;
  res_t       r0, r1;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign last        = in_ch.line_last;
  assign is_sep      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

  always_comb begin
    mode_nxt = mode_r;
    open_nxt = open_r;
    pend_nxt = pend_r;
    handled  = 1'b0;
    esc_v    = 1'b0;
    esc_ch   = CH_BSLASH;
    main_v   = 1'b0;
    closed   = 1'b0;

    if (pend_r) begin
      pend_nxt = 1'b0;
      esc_v    = 1'b1;
      handled  = 1'b1;
      case (c)
        CH_N:      esc_ch = CH_LF;
        CH_T:      esc_ch = CH_TAB;
        CH_DQUOTE: esc_ch = CH_DQUOTE;
        CH_BSLASH: esc_ch = CH_BSLASH;
        default: begin
          // unmapped escape: backslash kept, byte handled normally
          esc_ch  = CH_BSLASH;
          handled = 1'b0;
        end
      endcase
    end

    if (!handled) begin
      case (mode_r)
        QM_NONE: begin
          if (c == CH_DQUOTE) begin
            mode_nxt = QM_DOUBLE;
            open_nxt = 1'b1;
          end else if (c == CH_SQUOTE) begin
            mode_nxt = QM_SINGLE;
            open_nxt = 1'b1;
          end else if (is_sep) begin
            if (open_r) begin
              closed   = 1'b1;
              open_nxt = 1'b0;
            end
          end else begin
            open_nxt = 1'b1;
            main_v   = 1'b1;
          end
        end
        QM_SINGLE: begin
          if (c == CH_SQUOTE) begin
            mode_nxt = QM_NONE;
          end else begin
            main_v = 1'b1;
          end
        end
        QM_DOUBLE: begin
          if (c == CH_BSLASH && !last) begin
            pend_nxt = 1'b1;
          end else if (c == CH_DQUOTE) begin
            mode_nxt = QM_NONE;
          end else begin
            main_v = 1'b1;
          end
        end
        default: begin
          mode_nxt = QM_NONE;
        end
      endcase
    end

    err  = (mode_nxt != QM_NONE);
    tend = last ? ((open_nxt || closed) && !err) : closed;

    // first result: escape byte, plain byte, or a bare marker
    r0            = '0;
    r1            = '0;
    r0.char_valid = esc_v || main_v;
    if (esc_v) begin
      r0.out_char = esc_ch;
    end else if (main_v) begin
      r0.out_char = c;
    end
    r1.char_valid = main_v;
    r1.out_char   = main_v ? c : 8'h00;

    push_entry.two = esc_v && main_v;
    if (esc_v && main_v) begin
      r1.token_end   = tend;
      r1.line_end    = last;
      r1.quote_error = last && err;
      r1.run_last    = 1'b1;
    end else begin
      r0.token_end   = tend;
      r0.line_end    = last;
      r0.quote_error = last && err;
      r0.run_last    = 1'b1;
    end
    push_entry.r0 = r0;
    push_entry.r1 = r1;

    push = accept && (esc_v || main_v || last || closed);

    if (last) begin
      mode_nxt = QM_NONE;
      open_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= QM_NONE;
      open_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      open_r <= open_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

### design/qclt_queue.sv
// ----------------------------------------------------------------------------
// qclt_queue: entry queue between classifier and output sequencer
// Small circular buffer of classified entries in flip-flops.
// ----------------------------------------------------------------------------
module qclt_queue
  import qclt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### design/qclt_back.sv
// ----------------------------------------------------------------------------
// qclt_back: output sequencer of the tokenizer
// Drains queue entries into the output register, one result per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
module qclt_back
  import qclt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  entry_t       head,
  input  q_stat_t      q_stat,
  output logic         pop,
  qclt_out_if.source   out_ch
);

  logic out_valid_r, out_valid_nxt;
  logic sel_r, sel_nxt;
  res_t res_r, res_nxt;
  logic load;

  assign load = !out_valid_r || out_ch.ready;

  always_comb begin
    pop           = 1'b0;
    sel_nxt       = sel_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (head.two && !sel_r) begin
          // first of a pair: keep the entry for its second result
          res_nxt = head.r0;
          sel_nxt = 1'b1;
        end else begin
          res_nxt = sel_r ? head.r1 : head.r0;
          sel_nxt = 1'b0;
          pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = res_r.out_char;
  assign out_ch.char_valid  = res_r.char_valid;
  assign out_ch.token_end   = res_r.token_end;
  assign out_ch.line_end    = res_r.line_end;
  assign out_ch.quote_error = res_r.quote_error;
  assign out_ch.run_last    = res_r.run_last;

endmodule

### design/quoted_command_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer_top: shell-style command-line tokenizer
// Splits a byte stream into tokens, strips quotes and maps escapes.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_ch    | in        | in_byte, line_last
//  out_ch   | out       | out_char, char_valid, token_end, line_end,
//           |           | quote_error, run_last
//
//  one byte accepted per cycle unless the queue is full; output is registered
//  a byte with an unmapped escape gives two results and holds the output
//  register for both; the entry queue (QDEPTH entries) absorbs this
//  in_ch.ready drops only when the queue is full; output stalls back up into it
//  synchronous active-low reset; ready in the first cycle after reset
// ----------------------------------------------------------------------------
module quoted_command_line_tokenizer_top
  import qclt_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  qclt_in_if.sink     in_ch,
  qclt_out_if.source  out_ch
);

  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;
  q_stat_t q_stat;

  qclt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  qclt_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  qclt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### design/qclt_checker.sv
// ----------------------------------------------------------------------------
// qclt_checker: port-level checks of the tokenizer
// Result flag consistency and output stall behavior.
// ----------------------------------------------------------------------------
module qclt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_valid,
  input logic       token_end,
  input logic       line_end,
  input logic       quote_error,
  input logic       run_last
);

  // open quote is only reported at line end and never closes a token
  a_qerr_at_line_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && quote_error |-> line_end && !token_end)
    else $error("quote_error outside line end or with token_end");

  // a result without a byte exists only to carry an end marker
  a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> (token_end || line_end) && out_char == 8'h00)
    else $error("bare result without end marker");

  // line end is always the last result of its item
  a_line_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_end |-> run_last)
    else $error("line_end without run_last");

  // a token close ends the item's results
  a_tend_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_end |-> run_last)
    else $error("token_end without run_last");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
    else $error("output changed while stalled");

endmodule

bind quoted_command_line_tokenizer_top qclt_checker u_qclt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .char_valid  (out_ch.char_valid),
  .token_end   (out_ch.token_end),
  .line_end    (out_ch.line_end),
  .quote_error (out_ch.quote_error),
  .run_last    (out_ch.run_last)
);

### tb/tb_quoted_command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_command_line_tokenizer_top: self-checking bench of the tokenizer
// Drives command lines byte by byte, predicts every token result in the
// bench and checks the result stream in order under random idling and a
// long output stall.
// ----------------------------------------------------------------------------
module tb_quoted_command_line_tokenizer_top;
  import qclt_pkg::*;

  localparam int CLK_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  qclt_in_if  in_ch ();
  qclt_out_if out_ch ();

  quoted_command_line_tokenizer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted tokenizer state
  qmode_t tk_quote;
  logic   tk_in_token;
  logic   tk_esc_wait;

  res_t       token_exp_q[$];
  logic [7:0] line_buf[$];

  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   fail_cnt;
  int   cycle_cnt;
  logic rx_hold;
  event hold_off_ev;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t tok_byte(input logic [7:0] c, input logic v);
    res_t r;
    r = '0;
    r.out_char   = v ? c : 8'h00;
    r.char_valid = v;
    return r;
  endfunction

  // append one byte to the line under construction
  task automatic line_add(input logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  // expected results of one accepted byte
  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    res_t r [0:1];
    int   n;
    logic closed;
    logic handled;
    logic err;
    n       = 0;
    closed  = 1'b0;
    handled = 1'b0;
    if (tk_esc_wait) begin
      tk_esc_wait = 1'b0;
      handled     = 1'b1;
      case (c)
        CH_N: begin
          r[n] = tok_byte(CH_LF, 1'b1); n++;
        end
        CH_T: begin
          r[n] = tok_byte(CH_TAB, 1'b1); n++;
        end
        CH_DQUOTE, CH_BSLASH: begin
          r[n] = tok_byte(c, 1'b1); n++;
        end
        default: begin
          // unmapped escape keeps the backslash, byte handled below
          r[n] = tok_byte(CH_BSLASH, 1'b1); n++;
          handled = 1'b0;
        end
      endcase
    end
    if (!handled) begin
      if (tk_quote != QM_NONE) begin
        if (tk_quote == QM_DOUBLE && c == CH_BSLASH && !last) begin
          tk_esc_wait = 1'b1;
        end else if ((tk_quote == QM_DOUBLE && c == CH_DQUOTE) ||
                     (tk_quote == QM_SINGLE && c == CH_SQUOTE)) begin
          tk_quote = QM_NONE;
        end else begin
          r[n] = tok_byte(c, 1'b1); n++;
        end
      end else if (c == CH_DQUOTE) begin
        tk_quote    = QM_DOUBLE;
        tk_in_token = 1'b1;
      end else if (c == CH_SQUOTE) begin
        tk_quote    = QM_SINGLE;
        tk_in_token = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        if (tk_in_token) begin
          closed      = 1'b1;
          tk_in_token = 1'b0;
        end
      end else begin
        tk_in_token = 1'b1;
        r[n] = tok_byte(c, 1'b1); n++;
      end
    end
    if (last) begin
      err = (tk_quote != QM_NONE);
      if (n == 0) begin
        r[0] = tok_byte(8'h00, 1'b0); n = 1;
      end
      r[n-1].token_end   = (tk_in_token || closed) && !err;
      r[n-1].line_end    = 1'b1;
      r[n-1].quote_error = err;
      tk_quote    = QM_NONE;
      tk_in_token = 1'b0;
      tk_esc_wait = 1'b0;
    end else if (closed) begin
      if (n == 0) begin
        r[0] = tok_byte(8'h00, 1'b0); n = 1;
      end
      r[n-1].token_end = 1'b1;
    end
    if (n > 0) r[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) token_exp_q = {token_exp_q, r[i]};
  endtask

  // valid stays high after acceptance so back-to-back items need no re-raise
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= c;
    in_ch.line_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    tokenize_byte(c, last);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_byte(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_add(s[i]);
    send_line();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (token_exp_q.size() != 0) @(posedge clk);
  endtask

  // random line: words, separators, quoted runs with escapes, raw bytes
  task automatic build_line();
    int nseg;
    int len;
    line_buf.delete();
    nseg = $urandom_range(1, 5);
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 8, 9: begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) line_add(8'($urandom_range(0, 255)));
            else line_add(8'($urandom_range(8'h61, 8'h7A)));
          end
        end
        3: begin
          len = $urandom_range(1, 2);
          repeat (len) begin
            case ($urandom_range(0, 3))
              0: line_add(CH_SPACE);
              1: line_add(CH_TAB);
              2: line_add(CH_CR);
              default: line_add(CH_LF);
            endcase
          end
        end
        4, 5: begin
          line_add(CH_DQUOTE);
          len = $urandom_range(0, 4);
          repeat (len) begin
            if ($urandom_range(0, 2) == 0) begin
              line_add(CH_BSLASH);
              case ($urandom_range(0, 4))
                0: line_add(CH_N);
                1: line_add(CH_T);
                2: line_add(CH_DQUOTE);
                3: line_add(CH_BSLASH);
                default: line_add(8'($urandom_range(0, 255)));
              endcase
            end else if ($urandom_range(0, 2) == 0) begin
              line_add(8'($urandom_range(0, 255)));
            end else begin
              line_add(8'($urandom_range(8'h61, 8'h7A)));
            end
          end
          if ($urandom_range(0, 99) < 85) line_add(CH_DQUOTE);
          else if ($urandom_range(0, 1) == 0) line_add(CH_BSLASH);
        end
        6: begin
          line_add(CH_SQUOTE);
          len = $urandom_range(0, 3);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) line_add(CH_BSLASH);
            else line_add(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 99) < 85) line_add(CH_SQUOTE);
        end
        default: line_add(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_directed();
    send_text("a b");
    send_text("\t");
    send_text("''");
    // all four mapped escapes, an unmapped one, quote left open
    send_text("\"\\n\\t\\\"\\\\\\x");
    // backslash as the final byte inside double quotes
    send_text("\"\\");
    line_buf = '{8'h00, 8'hFF};
    send_line();
    line_buf = '{8'h78, CH_CR, CH_LF, 8'h79};
    send_line();
    drain_results();
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_line();
      send_line();
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_off_ev;
    // every byte of a plain word gives a result, so the queue fills
    send_text("backpressure_fill_word_0123456789");
    repeat (3) begin
      build_line();
      send_line();
    end
    drain_results();
  endtask

  // long output stall, counted here
  always begin
    @(hold_off_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_char: out_ch.out_char, char_valid: out_ch.char_valid,
              token_end: out_ch.token_end, line_end: out_ch.line_end,
              quote_error: out_ch.quote_error, run_last: out_ch.run_last};
      if (token_exp_q.size() == 0) begin
        $display("%0t: unexpected result char=%h valid=%b tend=%b lend=%b qerr=%b rlast=%b",
                 $time, got.out_char, got.char_valid, got.token_end, got.line_end,
                 got.quote_error, got.run_last);
        fail_cnt++;
      end else begin
        want = token_exp_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected char=%h valid=%b tend=%b lend=%b qerr=%b rlast=%b",
                   $time, want.out_char, want.char_valid, want.token_end, want.line_end,
                   want.quote_error, want.run_last);
          $display("%0t:          actual   char=%h valid=%b tend=%b lend=%b qerr=%b rlast=%b",
                   $time, got.out_char, got.char_valid, got.token_end, got.line_end,
                   got.quote_error, got.run_last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CLK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    rx_hold         = 1'b0;
    cycle_cnt       = 0;
    fail_cnt        = 0;
    items_sent      = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    tk_quote        = QM_NONE;
    tk_in_token     = 1'b0;
    tk_esc_wait     = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.line_last = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(14, 58, 110);
    test_random(58, 14, 110);
    test_random(0, 0, 110);
    test_backpressure();

    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
